FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds at an edge, so b holds at that same edge
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("assertion failed");

// a holds at an edge, so b holds at the next edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("assertion failed");

`endif

FILE: rtl/sme_pkg.sv
// types and codes of the stack machine executor
// no dependencies
package sme_pkg;

  localparam int unsigned WordW = 64;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_PRINT = 3'd1,
    OP_READ  = 3'd2,
    OP_ADD   = 3'd3,
    OP_STOP  = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_STOPPED   = 3'd1,
    ST_PUSH_OVF  = 3'd2,
    ST_PRINT_UNF = 3'd3,
    ST_READ_FAIL = 3'd4,
    ST_ADD_FAIL  = 3'd5,
    ST_UNKNOWN   = 3'd6,
    ST_HALTED    = 3'd7
  } status_e;

  // what every cell of the stack does at each clock edge
  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_DOWN = 2'd1,
    SH_UP   = 2'd2,
    SH_TOP  = 2'd3
  } shift_e;

  typedef struct packed {
    shift_e top_op;
    shift_e rest_op;
  } shift_ctrl_t;

endpackage

FILE: rtl/sme_cell.sv
// one stack entry of the shifting stack
// depends on sme_pkg
module sme_cell (
  input  logic           clk_i,
  input  sme_pkg::shift_e op_i,
  input  sme_pkg::word_t  above_i,
  input  sme_pkg::word_t  below_i,
  output sme_pkg::word_t  value_o
);
  import sme_pkg::*;

  word_t value_d, value_q;

  always_comb begin
    unique case (op_i)
      SH_HOLD: value_d = value_q;
      SH_DOWN: value_d = above_i;
      SH_UP:   value_d = below_i;
      SH_TOP:  value_d = above_i;
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

FILE: rtl/stack_machine_executor_unit.sv
// stack machine executor: top level with control, adder and output register
// depends on sme_pkg, sme_cell and assert_macros.svh
//
// usage:
// the input channel takes one instruction per item; tdata holds opcode,
// push_value and read_value, tuser holds read_ok. the output channel gives
// one result per item; tdata holds print_value and status, tuser holds
// print_valid.
// the stack is a row of STACK_DEPTH cells, cell 0 being the top; push,
// read, print and add shift the row by one place at once (add puts the sum
// in cell 0), and the one 64-bit adder sums cells 0 and 1.
// the result is registered and is shown in the cycle after the item is accepted.
// throughput: one item per cycle while the receiver takes results.
// the output register frees in the cycle its result is taken, so a new item
// is accepted while a result waits whenever m_axis_tready is high; if the
// receiver stalls, one result is held and input is stalled behind it.
// reset clears depth, halted flag and output valid; stack entries are not
// cleared and only entries below the depth are ever read.
// after stop or any error every item reports the halted status until reset.
`include "assert_macros.svh"

module stack_machine_executor_unit #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode [2:0], push_value [66:3], read_value [130:67], zero [135:131]
  input  logic [135:0] s_axis_tdata,
  // read_ok [0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // print_value [63:0], status [66:64], zero [71:67]
  output logic [71:0]  m_axis_tdata,
  // print_valid [0]
  output logic         m_axis_tuser
);
  import sme_pkg::*;

  localparam int unsigned DepthW = $clog2(STACK_DEPTH + 1);

  logic [2:0]        opcode;
  word_t             push_value, read_value;
  logic              read_ok;
  logic              s_fire;

  logic [DepthW-1:0] depth_d, depth_q;
  logic              halted_d, halted_q;
  logic              out_valid_d, out_valid_q;
  logic              print_valid_d, print_valid_q;
  word_t             print_value_d, print_value_q;
  status_e           status_d, status_q;

  word_t             cell_value [STACK_DEPTH];
  word_t             top_in, sum;
  shift_ctrl_t       ctrl;
  logic              is_full, is_empty, has_two;

  assign opcode     = s_axis_tdata[2:0];
  assign push_value = s_axis_tdata[66:3];
  assign read_value = s_axis_tdata[130:67];
  assign read_ok    = s_axis_tuser;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign is_full  = depth_q == DepthW'(STACK_DEPTH);
  assign is_empty = depth_q == '0;
  assign has_two  = depth_q >= DepthW'(2);
  assign sum      = cell_value[0] + cell_value[1];

  always_comb begin
    depth_d       = depth_q;
    halted_d      = halted_q;
    print_valid_d = 1'b0;
    print_value_d = '0;
    status_d      = ST_OK;
    top_in        = push_value;
    ctrl          = '{top_op: SH_HOLD, rest_op: SH_HOLD};
    if (halted_q) begin
      status_d = ST_HALTED;
    end else begin
      unique case (opcode)
        OP_PUSH: begin
          if (is_full) begin
            status_d = ST_PUSH_OVF;
          end else begin
            ctrl    = '{top_op: SH_DOWN, rest_op: SH_DOWN};
            depth_d = depth_q + DepthW'(1);
          end
        end
        OP_PRINT: begin
          if (is_empty) begin
            status_d = ST_PRINT_UNF;
          end else begin
            ctrl          = '{top_op: SH_UP, rest_op: SH_UP};
            depth_d       = depth_q - DepthW'(1);
            print_valid_d = 1'b1;
            print_value_d = cell_value[0];
          end
        end
        OP_READ: begin
          top_in = read_value;
          if (!read_ok || is_full) begin
            status_d = ST_READ_FAIL;
          end else begin
            ctrl    = '{top_op: SH_DOWN, rest_op: SH_DOWN};
            depth_d = depth_q + DepthW'(1);
          end
        end
        OP_ADD: begin
          top_in = sum;
          if (!has_two) begin
            status_d = ST_ADD_FAIL;
          end else begin
            ctrl    = '{top_op: SH_TOP, rest_op: SH_UP};
            depth_d = depth_q - DepthW'(1);
          end
        end
        OP_STOP: status_d = ST_STOPPED;
        default: status_d = ST_UNKNOWN;
      endcase
      if (status_d != ST_OK) begin
        halted_d = 1'b1;
      end
    end
    if (!s_fire) begin
      ctrl     = '{top_op: SH_HOLD, rest_op: SH_HOLD};
      depth_d  = depth_q;
      halted_d = halted_q;
    end
  end

  assign out_valid_d = s_fire || (out_valid_q && !m_axis_tready);

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    word_t above, below;
    if (i == 0) begin : g_top
      assign above = top_in;
    end else begin : g_mid
      assign above = cell_value[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = cell_value[i+1];
    end
    sme_cell u_cell (
      .clk_i   (clk_i),
      .op_i    ((i == 0) ? ctrl.top_op : ctrl.rest_op),
      .above_i (above),
      .below_i (below),
      .value_o (cell_value[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      depth_q     <= depth_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      print_valid_q <= print_valid_d;
      print_value_q <= print_value_d;
      status_q      <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, status_q, print_value_q};
  assign m_axis_tuser  = print_valid_q;

  `ASSERT_IMPL(a_depth_bound, clk_i, rst_ni, 1'b1, depth_q <= DepthW'(STACK_DEPTH))
  `ASSERT_NEXT(a_halt_sticky, clk_i, rst_ni, halted_q, halted_q)
  `ASSERT_IMPL(a_print_ok, clk_i, rst_ni, m_axis_tvalid && print_valid_q, status_q == ST_OK)
  `ASSERT_NEXT(a_halted_report, clk_i, rst_ni, s_fire && halted_q,
               out_valid_q && status_q == ST_HALTED && !print_valid_q)

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// testbench of stack_machine_executor_unit: directed table, then random programs
// that keep the machine running, then one randomly chosen way of halting it
// depends on sme_pkg and the rtl files; results are checked against a local model

module testbench;
  import sme_pkg::*;

  localparam int unsigned StackN = 16;
  localparam int BodyItems = 1380;
  localparam int HaltedItems = 30;
  localparam int HoldAt = 150;
  localparam int HoldCycles = 300;
  localparam int QuietLimit = 2000;
  localparam int DrainCycles = 4;
  localparam int ReportMax = 10;
  localparam logic [2:0] OpFirstUnknown = 3'd5;
  localparam logic [2:0] OpLastUnknown = 3'd7;
  localparam word_t WordMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam word_t WordMin = 64'h8000_0000_0000_0000;
  localparam word_t WordOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam word_t Alt5 = 64'h5555_5555_5555_5555;
  localparam word_t AltA = 64'hAAAA_AAAA_AAAA_AAAA;

  typedef struct packed {
    logic    shown;
    word_t   value;
    status_e status;
  } outcome_t;

  typedef struct {
    logic [2:0] op;
    word_t      push_arg;
    word_t      read_arg;
    logic       read_ok;
    bit         typed;
    outcome_t   want;
  } step_t;

  typedef enum int {
    EndStop,
    EndPushOvf,
    EndPrintUnf,
    EndReadBad,
    EndReadFull,
    EndAddFail,
    EndUnknown
  } ending_e;

  localparam outcome_t Quiet = '{1'b0, '0, ST_OK};
  localparam outcome_t Untyped = '0;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [71:0]  m_axis_tdata;
  logic         m_axis_tuser;

  word_t    stack_mem [StackN];
  int       depth_now = 0;
  bit       halted_now = 1'b0;
  outcome_t outcome_q [$];
  int       mismatches = 0;
  int       quiet_cycles = 0;
  int       sent = 0;
  bit       send_calm = 1'b0;

  step_t plan [20] = '{
    '{OP_PUSH,  WordMax, '0,       1'b0, 1'b1, Quiet},
    '{OP_PUSH,  64'd1,   '0,       1'b0, 1'b1, Quiet},
    '{OP_ADD,   '0,      '0,       1'b0, 1'b1, Quiet},
    '{OP_PRINT, '0,      '0,       1'b0, 1'b1, '{1'b1, WordMin, ST_OK}},
    '{OP_PUSH,  WordMin, WordOnes, 1'b0, 1'b1, Quiet},
    '{OP_PUSH,  WordMin, WordOnes, 1'b1, 1'b1, Quiet},
    '{OP_ADD,   WordOnes, WordMax, 1'b1, 1'b1, Quiet},
    '{OP_PRINT, WordOnes, WordMin, 1'b0, 1'b1, '{1'b1, '0, ST_OK}},
    '{OP_READ,  '0,      WordOnes, 1'b1, 1'b1, Quiet},
    '{OP_PUSH,  '0,      WordMax,  1'b0, 1'b1, Quiet},
    '{OP_ADD,   '0,      '0,       1'b0, 1'b1, Quiet},
    '{OP_PRINT, '0,      '0,       1'b0, 1'b1, '{1'b1, WordOnes, ST_OK}},
    '{OP_READ,  AltA,    Alt5,     1'b1, 1'b0, Untyped},
    '{OP_READ,  Alt5,    AltA,     1'b1, 1'b0, Untyped},
    '{OP_PRINT, '0,      '0,       1'b1, 1'b0, Untyped},
    '{OP_PRINT, '0,      '0,       1'b0, 1'b0, Untyped},
    '{OP_PUSH,  WordMin, '0,       1'b0, 1'b0, Untyped},
    '{OP_READ,  '0,      WordMax,  1'b1, 1'b0, Untyped},
    '{OP_ADD,   '0,      '0,       1'b0, 1'b0, Untyped},
    '{OP_PRINT, '0,      '0,       1'b0, 1'b1, '{1'b1, WordOnes, ST_OK}}
  };

  stack_machine_executor_unit #(
    .STACK_DEPTH(StackN)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic outcome_t execute_instr(logic [2:0] op, word_t push_arg,
                                             word_t read_arg, logic read_ok);
    outcome_t r;
    r = Quiet;
    if (halted_now) begin
      r.status = ST_HALTED;
    end else begin
      case (op)
        OP_PUSH: begin
          if (depth_now < StackN) begin
            stack_mem[depth_now] = push_arg;
            depth_now++;
          end else begin
            r.status = ST_PUSH_OVF;
          end
        end
        OP_PRINT: begin
          if (depth_now == 0) begin
            r.status = ST_PRINT_UNF;
          end else begin
            depth_now--;
            r.shown = 1'b1;
            r.value = stack_mem[depth_now];
          end
        end
        OP_READ: begin
          if (!read_ok || depth_now >= StackN) begin
            r.status = ST_READ_FAIL;
          end else begin
            stack_mem[depth_now] = read_arg;
            depth_now++;
          end
        end
        OP_ADD: begin
          if (depth_now < 2) begin
            r.status = ST_ADD_FAIL;
          end else begin
            stack_mem[depth_now-2] = stack_mem[depth_now-1] + stack_mem[depth_now-2];
            depth_now--;
          end
        end
        OP_STOP: r.status = ST_STOPPED;
        default: r.status = ST_UNKNOWN;
      endcase
      if (r.status != ST_OK) halted_now = 1'b1;
    end
    return r;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(7, 0))
      0: return WordMax;
      1: return WordMin;
      2: return '0;
      3: return WordOnes;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic coin();
    return 1'($urandom_range(1, 0));
  endfunction

  // legal instruction that keeps the machine running, biased up or down
  function automatic logic [2:0] pick_instr(bit filling);
    int grow_w, shrink_w, total, roll;
    grow_w = (depth_now < StackN) ? (filling ? 7 : 1) : 0;
    shrink_w = filling ? 1 : 7;
    total = 2 * grow_w + (depth_now >= 1 ? shrink_w : 0) + (depth_now >= 2 ? shrink_w : 0);
    roll = $urandom_range(total - 1, 0);
    if (roll < grow_w) return OP_PUSH;
    if (roll < 2 * grow_w) return OP_READ;
    if (roll < 2 * grow_w + shrink_w) return OP_PRINT;
    return OP_ADD;
  endfunction

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= ReportMax) $display("%s", msg);
  endtask

  task automatic offer(logic [2:0] op, word_t push_arg, word_t read_arg, logic read_ok,
                       bit typed, outcome_t want);
    int gap;
    outcome_t got;
    if (sent % 100 == 0) send_calm = ($urandom_range(2, 0) == 0);
    gap = send_calm ? 0 : $urandom_range(9, 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, read_arg, push_arg, op};
    s_axis_tuser <= read_ok;
    do @(posedge clk_i); while (!s_axis_tready);
    got = execute_instr(op, push_arg, read_arg, read_ok);
    outcome_q.push_back(typed ? want : got);
    sent++;
  endtask

  task automatic offer_rand(logic [2:0] op, logic read_ok);
    offer(op, rand_word(), rand_word(), read_ok, 1'b0, Untyped);
  endtask

  // receiver with random stalls and one long hold-off
  initial begin
    int wait_n;
    int taken;
    bit calm;
    taken = 0;
    calm = 1'b0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken % 80 == 0) calm = ($urandom_range(2, 0) == 0);
      if (taken == HoldAt) wait_n = HoldCycles;
      else wait_n = calm ? 0 : $urandom_range(9, 0);
      if (wait_n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  always @(posedge clk_i) begin
    outcome_t seen, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.shown = m_axis_tuser;
      seen.value = m_axis_tdata[63:0];
      seen.status = status_e'(m_axis_tdata[66:64]);
      if (outcome_q.size() == 0) begin
        flag_error($sformatf("unexpected result: shown=%b value=%h status=%0d",
                             seen.shown, seen.value, seen.status));
      end else begin
        want = outcome_q.pop_front();
        if (seen.shown !== want.shown || seen.value !== want.value
            || seen.status !== want.status) begin
          flag_error($sformatf(
            "mismatch: expected shown=%b value=%h status=%0d, got shown=%b value=%h status=%0d",
            want.shown, want.value, want.status, seen.shown, seen.value, seen.status));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    bit filling;
    int target;
    ending_e ending;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      offer(plan[i].op, plan[i].push_arg, plan[i].read_arg, plan[i].read_ok,
            plan[i].typed, plan[i].want);
    end

    filling = 1'b1;
    for (int n = 0; n < BodyItems; n++) begin
      if (n % 40 == 0) filling = coin();
      offer(pick_instr(filling), rand_word(), rand_word(), 1'b1, 1'b0, Untyped);
    end

    // halt the machine in one of its ways
    ending = ending_e'($urandom_range(EndUnknown, EndStop));
    case (ending)
      EndStop: offer_rand(OP_STOP, coin());
      EndPushOvf: begin
        while (depth_now < StackN) offer_rand(OP_PUSH, coin());
        offer_rand(OP_PUSH, coin());
      end
      EndPrintUnf: begin
        while (depth_now > 0) offer_rand(OP_PRINT, coin());
        offer_rand(OP_PRINT, coin());
      end
      EndReadBad: offer_rand(OP_READ, 1'b0);
      EndReadFull: begin
        while (depth_now < StackN) offer_rand(OP_READ, 1'b1);
        offer_rand(OP_READ, 1'b1);
      end
      EndAddFail: begin
        target = $urandom_range(1, 0);
        while (depth_now > target) offer_rand(OP_PRINT, coin());
        offer_rand(OP_ADD, coin());
      end
      default: offer_rand(3'($urandom_range(OpLastUnknown, OpFirstUnknown)), coin());
    endcase

    repeat (HaltedItems) offer_rand(3'($urandom_range(OpLastUnknown, OP_PUSH)), coin());
    s_axis_tvalid <= 1'b0;

    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
